FILE: sv/lewe_pkg.sv
// Shared types and constants for the line editor with echo.
// Used by lewe_front, lewe_queue, lewe_back and line_editor_with_echo.
package lewe_pkg;

	// Line store geometry
	localparam int LINE_DEPTH = 32;
	localparam int FILL_W     = $clog2(LINE_DEPTH);
	localparam int MAXLEN_W   = 6;
	localparam int LEN_W      = 5;
	localparam int CFG_IDX_W  = 1;
	localparam int QDEPTH     = 2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ECHO_ENABLE = 1'd1;

	// Reset values of the configuration registers
	localparam logic [MAXLEN_W-1:0] MAX_LENGTH_RST = 6'd32;
	localparam logic                ECHO_RST       = 1'b1;

	// Character codes
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_DEL   = 8'h7F;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// Result kinds
	localparam logic [1:0] KIND_ECHO = 2'd0;
	localparam logic [1:0] KIND_BYTE = 2'd1;
	localparam logic [1:0] KIND_END  = 2'd2;

	// Echo sequence selected by the front end
	typedef enum logic [1:0] {
		ECHO_NONE,
		ECHO_CHAR,
		ECHO_RUB,
		ECHO_CRLF
	} echo_t;

	// Command passed from front to back through the queue
	typedef struct packed {
		echo_t             echo;
		logic [7:0]        data;
		logic              ends;
		logic [FILL_W-1:0] len;
	} cmd_t;

	// Line store write port, driven by the front end
	typedef struct packed {
		logic              we;
		logic [FILL_W-1:0] addr;
		logic [7:0]        data;
	} stw_t;

endpackage

FILE: sv/lewe_front.sv
// Front end: accepts received bytes, classifies them, keeps the fill count
// and configuration, writes the line store and queues commands. Uses lewe_pkg.
module lewe_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [lewe_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lewe_pkg::MAXLEN_W-1:0]    cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [7:0]                       rx_byte,
	input  logic                             q_full,
	output logic                             q_push,
	output lewe_pkg::cmd_t                   q_cmd,
	output lewe_pkg::stw_t                   st_wr,
	input  logic                             dump_done
);

	logic [lewe_pkg::MAXLEN_W-1:0] max_length_q;
	logic                          echo_enable_q;
	logic [lewe_pkg::FILL_W-1:0]   fill_q;
	logic                          busy_q;

	logic [lewe_pkg::MAXLEN_W-1:0] limit;
	logic [lewe_pkg::FILL_W-1:0]   stop;
	logic [lewe_pkg::FILL_W-1:0]   fill_nxt;
	logic                          is_eol;
	logic                          is_rub;
	logic                          store_we;
	logic                          ends;
	logic                          accept;
	lewe_pkg::echo_t               echo;

	// Line limit saturated to [2, LINE_DEPTH]; the line ends at limit - 1
	always_comb begin
		if (max_length_q < lewe_pkg::MAXLEN_W'(2)) begin
			limit = lewe_pkg::MAXLEN_W'(2);
		end else if (max_length_q > lewe_pkg::MAXLEN_W'(lewe_pkg::LINE_DEPTH)) begin
			limit = lewe_pkg::MAXLEN_W'(lewe_pkg::LINE_DEPTH);
		end else begin
			limit = max_length_q;
		end
		stop = lewe_pkg::FILL_W'(limit - lewe_pkg::MAXLEN_W'(1));
	end

	// Classify the byte and work out the new fill count
	always_comb begin
		is_eol   = (rx_byte == lewe_pkg::CH_CR) || (rx_byte == lewe_pkg::CH_LF);
		is_rub   = (rx_byte == lewe_pkg::CH_BS) || (rx_byte == lewe_pkg::CH_DEL);
		fill_nxt = fill_q;
		store_we = 1'b0;
		echo     = lewe_pkg::ECHO_NONE;
		ends     = 1'b0;
		if (is_eol) begin
			ends = 1'b1;
			if (echo_enable_q) begin
				echo = lewe_pkg::ECHO_CRLF;
			end
		end else if (is_rub) begin
			if (fill_q != '0) begin
				fill_nxt = fill_q - lewe_pkg::FILL_W'(1);
				if (echo_enable_q) begin
					echo = lewe_pkg::ECHO_RUB;
				end
			end
		end else if (fill_q < stop) begin
			fill_nxt = fill_q + lewe_pkg::FILL_W'(1);
			store_we = 1'b1;
			if (echo_enable_q) begin
				echo = lewe_pkg::ECHO_CHAR;
			end
		end
		if (fill_nxt >= stop) begin
			ends = 1'b1;
		end
	end

	// Hold off while a line is dumped from the store or the queue is full
	assign in_ready = !busy_q && !q_full;
	assign accept   = in_valid && in_ready;
	assign q_push   = accept && ((echo != lewe_pkg::ECHO_NONE) || ends);

	always_comb begin
		q_cmd.echo = echo;
		q_cmd.data = rx_byte;
		q_cmd.ends = ends;
		q_cmd.len  = fill_nxt;
		st_wr.we   = accept && store_we;
		st_wr.addr = fill_q;
		st_wr.data = rx_byte;
	end

	// Configuration, fill count and dump interlock
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q  <= lewe_pkg::MAX_LENGTH_RST;
			echo_enable_q <= lewe_pkg::ECHO_RST;
			fill_q        <= '0;
			busy_q        <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					lewe_pkg::REG_MAX_LENGTH:  max_length_q  <= cfg_data;
					lewe_pkg::REG_ECHO_ENABLE: echo_enable_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (accept) begin
				fill_q <= ends ? '0 : fill_nxt;
			end
			if (dump_done) begin
				busy_q <= 1'b0;
			end else if (q_push && ends) begin
				busy_q <= 1'b1;
			end
		end
	end

	// A queued line end locks the input until the back end has finished it
	a_busy_set: assert property (@(posedge clk) disable iff (!arst_n)
		q_push && q_cmd.ends |=> busy_q)
		else $error("line end queued without input interlock");
	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !st_wr.we)
		else $error("line store written during a dump");

endmodule

FILE: sv/lewe_queue.sv
// Short command queue between the front and back ends.
// Uses lewe_pkg for the command type and depth.
module lewe_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lewe_pkg::cmd_t push_cmd,
	input  logic           pop,
	output lewe_pkg::cmd_t pop_cmd,
	output logic           full,
	output logic           empty
);

	localparam int PTR_W = (lewe_pkg::QDEPTH > 1) ? $clog2(lewe_pkg::QDEPTH) : 1;
	localparam int CNT_W = $clog2(lewe_pkg::QDEPTH + 1);

	lewe_pkg::cmd_t   slots_q [lewe_pkg::QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = (count_q == CNT_W'(lewe_pkg::QDEPTH));
	assign empty   = (count_q == '0);
	assign pop_cmd = slots_q[rd_ptr_q];

	// Payload slots
	always_ff @(posedge clk) begin
		if (push && !full) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(lewe_pkg::QDEPTH - 1)) ?
					'0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop && !empty) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(lewe_pkg::QDEPTH - 1)) ?
					'0 : rd_ptr_q + PTR_W'(1);
			end
			case ({push && !full, pop && !empty})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: ;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("command pushed into full queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(lewe_pkg::QDEPTH))
		else $error("queue occupancy out of range");

endmodule

FILE: sv/lewe_back.sv
// Back end: executes queued commands, emitting echo bytes, the stored line
// and the line end item. Holds the line store. Uses lewe_pkg.
module lewe_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_empty,
	output logic                       q_pop,
	input  lewe_pkg::cmd_t             q_cmd,
	input  lewe_pkg::stw_t             st_wr,
	output logic                       dump_done,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [1:0]                 kind,
	output logic [7:0]                 data_byte,
	output logic [lewe_pkg::LEN_W-1:0] line_length,
	output logic                       last
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ECHO,
		S_RD,
		S_BYTE,
		S_END
	} state_t;

	state_t                      state_q;
	lewe_pkg::cmd_t              cmd_q;
	logic [1:0]                  step_q;
	logic [lewe_pkg::FILL_W-1:0] idx_q;
	logic [7:0]                  rdata_q;
	logic [7:0]                  store_mem [lewe_pkg::LINE_DEPTH];

	logic                        out_valid_q;
	logic [1:0]                  kind_q;
	logic [7:0]                  data_q;
	logic [lewe_pkg::LEN_W-1:0]  len_q;
	logic                        last_q;

	logic                        slot_free;
	logic [1:0]                  echo_last;
	logic [7:0]                  echo_byte;

	assign slot_free   = !out_valid_q || out_ready;
	assign q_pop       = (state_q == S_IDLE) && !q_empty;
	assign dump_done   = (state_q == S_END) && slot_free && cmd_q.ends;
	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign data_byte   = data_q;
	assign line_length = len_q;
	assign last        = last_q;

	// Echo sequence: length and byte at the current step
	always_comb begin
		echo_last = 2'd0;
		echo_byte = cmd_q.data;
		case (cmd_q.echo)
			lewe_pkg::ECHO_RUB: begin
				echo_last = 2'd2;
				echo_byte = (step_q == 2'd1) ? lewe_pkg::CH_SPACE : lewe_pkg::CH_BS;
			end
			lewe_pkg::ECHO_CRLF: begin
				echo_last = 2'd1;
				echo_byte = (step_q == 2'd0) ? lewe_pkg::CH_CR : lewe_pkg::CH_LF;
			end
			default: ;
		endcase
	end

	// Line store: written by the front end, read one entry per dump step
	always_ff @(posedge clk) begin
		if (st_wr.we) begin
			store_mem[st_wr.addr] <= st_wr.data;
		end
		if (state_q == S_RD) begin
			rdata_q <= store_mem[idx_q];
		end
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			step_q      <= '0;
			idx_q       <= '0;
			cmd_q       <= '0;
			kind_q      <= '0;
			data_q      <= '0;
			len_q       <= '0;
			last_q      <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						cmd_q  <= q_cmd;
						step_q <= '0;
						idx_q  <= '0;
						if (q_cmd.echo != lewe_pkg::ECHO_NONE) begin
							state_q <= S_ECHO;
						end else if (q_cmd.len == '0) begin
							state_q <= S_END;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_ECHO: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						kind_q      <= lewe_pkg::KIND_ECHO;
						data_q      <= echo_byte;
						len_q       <= '0;
						last_q      <= (step_q == echo_last) && !cmd_q.ends;
						if (step_q == echo_last) begin
							if (!cmd_q.ends) begin
								state_q <= S_IDLE;
							end else if (cmd_q.len == '0) begin
								state_q <= S_END;
							end else begin
								state_q <= S_RD;
							end
						end else begin
							step_q <= step_q + 2'd1;
						end
					end
				end
				S_RD: begin
					state_q <= S_BYTE;
				end
				S_BYTE: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						kind_q      <= lewe_pkg::KIND_BYTE;
						data_q      <= rdata_q;
						len_q       <= '0;
						last_q      <= 1'b0;
						if (idx_q == cmd_q.len - lewe_pkg::FILL_W'(1)) begin
							state_q <= S_END;
						end else begin
							idx_q   <= idx_q + lewe_pkg::FILL_W'(1);
							state_q <= S_RD;
						end
					end
				end
				S_END: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						kind_q      <= lewe_pkg::KIND_END;
						data_q      <= '0;
						len_q       <= lewe_pkg::LEN_W'(cmd_q.len);
						last_q      <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_byte_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (kind_q == lewe_pkg::KIND_BYTE) |-> !last_q)
		else $error("line byte flagged as final result");
	a_dump_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD || state_q == S_BYTE) |-> (idx_q < cmd_q.len))
		else $error("dump index beyond line length");
	a_dump_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD || state_q == S_BYTE || state_q == S_END) |-> cmd_q.ends)
		else $error("dump started for a command without line end");

endmodule

FILE: sv/line_editor_with_echo.sv
// Top level of the line editor with echo: front end, command queue, back end.
// Depends on lewe_pkg, lewe_front, lewe_queue and lewe_back.
//
// Usage: received bytes enter on in_valid/in_ready with rx_byte. Results
// leave on out_valid/out_ready with kind (0 echo, 1 line byte, 2 line end),
// data_byte, line_length and last; last marks the final result caused by
// one received byte. A byte that causes nothing produces no transfer.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 max_length, 1 echo_enable) at the clock edge; the user must write
// only while idle, which the block itself does not enforce.
// Flow: the front end takes one byte per cycle, when not held off, into
// a two-entry command queue. The back end fetches a command, emits its
// echo results, reads each line byte from the line store and outputs
// it, then the line end item. Input is held off from a line end until its
// end item is placed in the output register, as the line store is shared.
// Reset clears the fill count, queue and output register and restores
// max_length to 32 and echo on; the line store is not cleared.
// A stalled receiver holds the output register, and the back end waits;
// the front end accepts until the queue fills or a line end locks input.
module line_editor_with_echo (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [lewe_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lewe_pkg::MAXLEN_W-1:0]    cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [7:0]                       rx_byte,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [1:0]                       kind,
	output logic [7:0]                       data_byte,
	output logic [lewe_pkg::LEN_W-1:0]       line_length,
	output logic                             last
);

	logic           q_full;
	logic           q_empty;
	logic           q_push;
	logic           q_pop;
	logic           dump_done;
	lewe_pkg::cmd_t push_cmd;
	lewe_pkg::cmd_t pop_cmd;
	lewe_pkg::stw_t st_wr;

	lewe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rx_byte   (rx_byte),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_cmd     (push_cmd),
		.st_wr     (st_wr),
		.dump_done (dump_done)
	);

	lewe_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.pop      (q_pop),
		.pop_cmd  (pop_cmd),
		.full     (q_full),
		.empty    (q_empty)
	);

	lewe_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.q_cmd       (pop_cmd),
		.st_wr       (st_wr),
		.dump_done   (dump_done),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.data_byte   (data_byte),
		.line_length (line_length),
		.last        (last)
	);

endmodule
